### hdl/spps_pkg.sv
// Shared constants, types and helpers for the servo packet parameter store.
package spps_pkg;

  localparam int DEF_PARAM_COUNT = 10;
  localparam int DEF_MAX_PAYLOAD = 10;
  localparam int QDEPTH          = 2;
  localparam int M_TDATA_W       = 24;

  localparam logic [7:0] HDR_BYTE    = 8'hFF;
  localparam logic [7:0] INSTR_READ  = 8'd1;
  localparam logic [7:0] INSTR_WRITE = 8'd2;
  localparam logic [7:0] INSTR_RESET = 8'd3;

  // command kinds handed from parser to executor
  typedef enum logic [1:0] {
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_RESET = 2'd3
  } op_t;

  function automatic int len_width(int max_payload);
    return $clog2(max_payload + 1);
  endfunction

  // command word: [1:0] op, [9:2] id, then length, then payload bytes
  function automatic int cmd_width(int max_payload);
    return 2 + 8 + len_width(max_payload) + 8 * max_payload;
  endfunction

  function automatic logic [7:0] default_value(int i);
    logic [7:0] v;
    if (i inside {0, 1, 2, 4, 5}) v = 8'd127;
    else v = 8'd0;
    return v;
  endfunction

endpackage

### hdl/spps_front.sv
// Packet parser: header hunt, field capture, checksum test, command push.
module spps_front #(
  parameter int MAX_PAYLOAD = spps_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  input  logic [7:0]                                   s_tdata,
  output logic                                         push,
  output logic [spps_pkg::cmd_width(MAX_PAYLOAD)-1:0]  cmd,
  input  logic                                         full
);
  import spps_pkg::*;

  localparam int LEN_W = len_width(MAX_PAYLOAD);
  localparam int PW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int PB    = 10 + LEN_W;

  typedef enum logic [2:0] {
    PH_HUNT1, PH_HUNT2, PH_ID, PH_INSTR, PH_LEN, PH_PAYLOAD, PH_CHECK
  } phase_t;

  phase_t           phase;
  logic [7:0]       id;
  logic [7:0]       instr;
  logic [7:0]       len;
  logic [7:0]       sum;
  logic [LEN_W-1:0] count;
  logic [7:0]       pay [MAX_PAYLOAD];
  logic             take;
  logic             sum_ok;
  logic             op_known;
  logic             pay_wr;
  op_t              op;

  // only the checksum beat can push, so only it waits on a full queue
  assign s_tready = !(phase == PH_CHECK && full);
  assign take     = s_tvalid && s_tready;
  assign sum_ok   = (~sum == s_tdata);
  assign pay_wr   = take && phase == PH_PAYLOAD && s_tdata != HDR_BYTE &&
                    count < LEN_W'(MAX_PAYLOAD);

  always_comb begin
    op       = OP_READ;
    op_known = 1'b1;
    case (instr)
      INSTR_READ:  op = OP_READ;
      INSTR_WRITE: op = OP_WRITE;
      INSTR_RESET: op = OP_RESET;
      default:     op_known = 1'b0;
    endcase
  end

  assign push = take && phase == PH_CHECK && sum_ok && op_known;

  always_comb begin
    cmd = '0;
    cmd[1:0]        = op;
    cmd[9:2]        = id;
    cmd[10 +: LEN_W] = len[LEN_W-1:0];
    for (int i = 0; i < MAX_PAYLOAD; i++) cmd[PB + 8*i +: 8] = pay[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT1;
      id    <= 8'd0;
      instr <= 8'd0;
      len   <= 8'd0;
      sum   <= 8'd0;
      count <= '0;
    end else if (take) begin
      case (phase)
        PH_HUNT1: if (s_tdata == HDR_BYTE) phase <= PH_HUNT2;
        PH_HUNT2: phase <= (s_tdata == HDR_BYTE) ? PH_ID : PH_HUNT1;
        PH_ID: begin
          id    <= s_tdata;
          sum   <= s_tdata;
          phase <= PH_INSTR;
        end
        PH_INSTR: begin
          instr <= s_tdata;
          sum   <= sum + s_tdata;
          phase <= PH_LEN;
        end
        PH_LEN: begin
          len   <= s_tdata;
          sum   <= sum + s_tdata;
          count <= '0;
          if (s_tdata > 8'(MAX_PAYLOAD)) phase <= PH_HUNT1;
          else if (s_tdata == 8'd0) phase <= PH_CHECK;
          else phase <= PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (!pay_wr) begin
            phase <= PH_HUNT1;
          end else begin
            sum   <= sum + s_tdata;
            count <= count + 1'b1;
            if (8'(count) + 8'd1 >= len) phase <= PH_CHECK;
          end
        end
        PH_CHECK: phase <= PH_HUNT1;
        default:  phase <= PH_HUNT1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pay_wr) pay[count[PW-1:0]] <= s_tdata;
  end

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command pushed into full queue");
`endif

endmodule

### hdl/spps_queue.sv
// Two-entry command queue between parser and executor.
module spps_queue #(
  parameter int W = spps_pkg::cmd_width(spps_pkg::DEF_MAX_PAYLOAD)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  import spps_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic [W-1:0]     mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow push");
`endif

endmodule

### hdl/spps_back.sv
// Command executor: parameter bank, write updates, read reply, output register.
module spps_back #(
  parameter int PARAM_COUNT = spps_pkg::DEF_PARAM_COUNT,
  parameter int MAX_PAYLOAD = spps_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic [spps_pkg::cmd_width(MAX_PAYLOAD)-1:0] cmd,
  input  logic                                        empty,
  output logic                                        pop,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  output logic [spps_pkg::M_TDATA_W-1:0]              m_tdata,
  output logic                                        m_tuser,
  output logic                                        m_tlast
);
  import spps_pkg::*;

  localparam int LEN_W = len_width(MAX_PAYLOAD);
  localparam int IDX_W = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
  localparam int NPAIR = (MAX_PAYLOAD / 2 > 0) ? MAX_PAYLOAD / 2 : 1;
  localparam int SH_N  = MAX_PAYLOAD + 2;
  localparam int POS_W = $clog2(2 * MAX_PAYLOAD + 6);
  localparam int PB    = 10 + LEN_W;

  localparam logic [POS_W-1:0] POS_HDR1 = POS_W'(1);
  localparam logic [POS_W-1:0] POS_ID   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_INS  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_LEN  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_BODY = POS_W'(5);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WRITE} state_t;

  state_t            state;
  logic [7:0]        store [PARAM_COUNT];
  logic [7:0]        id;
  logic [LEN_W-1:0]  len;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  last_pos;
  logic [7:0]        sum;
  logic [7:0]        cur_p;
  logic [NPAIR-1:0]  ok;
  logic [8*SH_N-1:0] pay_sh;
  op_t               c_op;
  logic [7:0]        c_id;
  logic [LEN_W-1:0]  c_len;
  logic [NPAIR-1:0]  c_ok;
  logic              out_free;
  logic [7:0]        rd_val;
  logic [7:0]        rd_byte;
  logic              wr_en;

  assign c_op  = op_t'(cmd[1:0]);
  assign c_id  = cmd[9:2];
  assign c_len = cmd[10 +: LEN_W];

  // pairs that will really update a register
  always_comb begin
    for (int k = 0; k < NPAIR; k++) begin
      c_ok[k] = (c_len > LEN_W'(2*k + 1)) && (cmd[PB + 16*k +: 8] < 8'(PARAM_COUNT));
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign pop      = (state == S_IDLE) && !empty;
  assign last_pos = POS_W'({len, 1'b0}) + POS_BODY;
  assign rd_val   = (cur_p < 8'(PARAM_COUNT)) ? store[cur_p[IDX_W-1:0]] : 8'd0;
  assign wr_en    = (state == S_WRITE) && out_free && ok[0];

  // reply byte at the current position
  always_comb begin
    if (pos == last_pos) rd_byte = ~sum;
    else if (pos <= POS_HDR1) rd_byte = HDR_BYTE;
    else if (pos == POS_ID) rd_byte = id;
    else if (pos == POS_INS) rd_byte = INSTR_READ;
    else if (pos == POS_LEN) rd_byte = 8'(len);
    else if (pos[0]) rd_byte = pay_sh[7:0];
    else rd_byte = rd_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (out_free) m_tvalid <= 1'b0;
          if (!empty) begin
            id     <= c_id;
            len    <= c_len;
            pos    <= '0;
            sum    <= c_id + INSTR_READ + 8'(c_len);
            ok     <= c_ok;
            pay_sh <= {16'h0000, cmd[PB +: 8*MAX_PAYLOAD]};
            case (c_op)
              OP_READ:  state <= S_READ;
              OP_WRITE: if (c_ok != '0) state <= S_WRITE;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_READ: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= 1'b0;
            m_tlast  <= (pos == last_pos);
            m_tdata  <= {{(M_TDATA_W-8){1'b0}}, rd_byte};
            pos      <= pos + 1'b1;
            if (pos == last_pos) begin
              state <= S_IDLE;
            end else if (pos >= POS_BODY) begin
              if (pos[0]) begin
                cur_p <= pay_sh[7:0];
                sum   <= sum + pay_sh[7:0];
              end else begin
                sum    <= sum + rd_val;
                pay_sh <= pay_sh >> 8;
              end
            end
          end
        end
        S_WRITE: begin
          if (out_free) begin
            m_tvalid <= ok[0];
            if (ok[0]) begin
              m_tuser  <= 1'b1;
              m_tlast  <= ((ok >> 1) == '0);
              m_tdata  <= {{(M_TDATA_W-20){1'b0}}, pay_sh[15:8], pay_sh[3:0], 8'h00};
            end
            ok     <= ok >> 1;
            pay_sh <= pay_sh >> 16;
            if ((ok >> 1) == '0) state <= S_IDLE;
          end
        end
        default: begin
          if (out_free) m_tvalid <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (pop && c_op == OP_RESET)) begin
      for (int i = 0; i < PARAM_COUNT; i++) store[i] <= default_value(i);
    end else if (wr_en) begin
      store[pay_sh[IDX_W-1:0]] <= pay_sh[15:8];
    end
  end

`ifndef SYNTHESIS
  a_write_has_pair: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> ok != '0)
    else $error("write sequencer with no pending pair");
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> pos <= last_pos)
    else $error("read reply position past checksum");
`endif

endmodule

### hdl/servo_packet_parameter_store_core.sv
// Top level of the servo packet parameter store: parser, command queue, executor.
//
//  channel  dir  beat contents
//  -------  ---  ------------------------------------------------------------
//  s_*      in   s_tdata[7:0] rx_byte, one received command stream byte
//  m_*      out  m_tdata reply_byte/param_index/param_value, m_tuser kind,
//                m_tlast on final result of the causing byte
//
// Cycles: the parser takes one byte per cycle; only a checksum beat waits,
// and only while two completed commands are queued.
// The executor loads a command from the queue, then sends 2L+6 reply beats for
// a read of length L, steps through the payload pairs up to the last stored one
// for a write, and sends nothing for a reset.
// Output beats come from a single output register, one per cycle when m_tready.
// Reset (rst, synchronous) returns the parser to header hunt, empties the
// queue and reloads the parameter defaults in the same cycle; no clearing pass.
module servo_packet_parameter_store_core #(
  parameter int PARAM_COUNT = spps_pkg::DEF_PARAM_COUNT,
  parameter int MAX_PAYLOAD = spps_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [spps_pkg::M_TDATA_W-1:0] m_tdata,   // [7:0] reply_byte, [11:8] param_index,
                                                    // [19:12] param_value, rest zero
  output logic                           m_tuser,   // [0] kind: 0 reply, 1 update
  output logic                           m_tlast
);
  import spps_pkg::*;

  localparam int CMD_W = cmd_width(MAX_PAYLOAD);

  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  logic [CMD_W-1:0] cmd_in;
  logic [CMD_W-1:0] cmd_out;

  // front: byte parser, pushes validated read/write/reset commands
  spps_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .push     (push),
    .cmd      (cmd_in),
    .full     (full)
  );

  // short queue: parser keeps taking bytes while a long reply drains
  spps_queue #(
    .W(CMD_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd_in),
    .full  (full),
    .pop   (pop),
    .dout  (cmd_out),
    .empty (empty)
  );

  // back: parameter bank and result sequencer
  spps_back #(
    .PARAM_COUNT(PARAM_COUNT),
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_out),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

### tb/servo_packet_parameter_store_core_tb.sv
// Self-checking testbench: scripted and random command streams against a packet parser model.
module servo_packet_parameter_store_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spps_pkg::*;

  localparam int REG_COUNT    = DEF_PARAM_COUNT;
  localparam int MAX_LEN      = DEF_MAX_PAYLOAD;
  localparam int RANDOM_BYTES = 280;
  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE       = 64;
  localparam int SCRIPT_LEN   = 51;

  typedef enum logic [2:0] {
    SEEK_FIRST, SEEK_SECOND, GET_ID, GET_INSTR, GET_LEN, GET_PAYLOAD, GET_CHECK
  } rx_phase_t;

  // one output beat, as the parser/executor should produce it
  typedef struct packed {
    logic       kind;
    logic [7:0] reply;
    logic [3:0] idx;
    logic [7:0] val;
    logic       last;
  } beat_t;

  // scripted byte plus how many of its result beats are typed in below
  typedef struct packed {
    logic [7:0] rx;
    logic [3:0] ntyped;
  } script_row_t;

  localparam logic [7:0] FACTORY_VALUES [REG_COUNT] =
    '{8'd127, 8'd127, 8'd127, 8'd0, 8'd127, 8'd127, 8'd0, 8'd0, 8'd0, 8'd0};

  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // broken header: second byte is not FF
    '{8'hFF, 4'd0}, '{8'h00, 4'd0},
    // FF FF FF: id FF, reset instruction, zero length
    '{8'hFF, 4'd0}, '{8'hFF, 4'd0}, '{8'hFF, 4'd0}, '{8'h03, 4'd0}, '{8'h00, 4'd0},
    '{8'hFD, 4'd0},
    // write, odd length: reg 9 <= FE, index 0A dropped, trailing 77 ignored
    '{8'hFF, 4'd0}, '{8'hFF, 4'd0}, '{8'h01, 4'd0}, '{8'h02, 4'd0}, '{8'h05, 4'd0},
    '{8'h09, 4'd0}, '{8'hFE, 4'd0}, '{8'h0A, 4'd0}, '{8'h33, 4'd0}, '{8'h77, 4'd0},
    '{8'h3C, 4'd1},
    // read regs 9, 0F (out of range) and 0
    '{8'hFF, 4'd0}, '{8'hFF, 4'd0}, '{8'h05, 4'd0}, '{8'h01, 4'd0}, '{8'h03, 4'd0},
    '{8'h09, 4'd0}, '{8'h0F, 4'd0}, '{8'h00, 4'd0}, '{8'hDE, 4'd12},
    // length above capacity
    '{8'hFF, 4'd0}, '{8'hFF, 4'd0}, '{8'h00, 4'd0}, '{8'h00, 4'd0}, '{8'h0B, 4'd0},
    // FF inside the payload
    '{8'hFF, 4'd0}, '{8'hFF, 4'd0}, '{8'h00, 4'd0}, '{8'h02, 4'd0}, '{8'h01, 4'd0},
    '{8'hFF, 4'd0},
    // bad checksum (FE would be right)
    '{8'hFF, 4'd0}, '{8'hFF, 4'd0}, '{8'h00, 4'd0}, '{8'h01, 4'd0}, '{8'h00, 4'd0},
    '{8'h00, 4'd0},
    // unknown instruction 07 with good checksum
    '{8'hFF, 4'd0}, '{8'hFF, 4'd0}, '{8'h00, 4'd0}, '{8'h07, 4'd0}, '{8'h00, 4'd0},
    '{8'hF8, 4'd0}
  };

  localparam beat_t SCRIPT_BEATS [13] = '{
    '{1'b1, 8'h00, 4'd9, 8'hFE, 1'b1},
    '{1'b0, 8'hFF, 4'd0, 8'h00, 1'b0}, '{1'b0, 8'hFF, 4'd0, 8'h00, 1'b0},
    '{1'b0, 8'h05, 4'd0, 8'h00, 1'b0}, '{1'b0, 8'h01, 4'd0, 8'h00, 1'b0},
    '{1'b0, 8'h03, 4'd0, 8'h00, 1'b0}, '{1'b0, 8'h09, 4'd0, 8'h00, 1'b0},
    '{1'b0, 8'hFE, 4'd0, 8'h00, 1'b0}, '{1'b0, 8'h0F, 4'd0, 8'h00, 1'b0},
    '{1'b0, 8'h00, 4'd0, 8'h00, 1'b0}, '{1'b0, 8'h00, 4'd0, 8'h00, 1'b0},
    '{1'b0, 8'h7F, 4'd0, 8'h00, 1'b0}, '{1'b0, 8'h61, 4'd0, 8'h00, 1'b1}
  };

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  // parser model state
  rx_phase_t  phase;
  logic [7:0] cur_id, cur_instr, cur_len, cur_sum;
  int         cur_count;
  logic [7:0] cur_payload [MAX_LEN];
  logic [7:0] regs [REG_COUNT];

  beat_t fresh_beats [$];
  beat_t pending_beats [$];

  bit steady = 1'b0;   // no idling on either side while set
  int typed_pos = 0;
  int bytes_sent = 0;
  int packets_sent = 0;
  int beats_checked = 0;
  int updates_seen = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  servo_packet_parameter_store_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  function automatic void restore_regs();
    for (int i = 0; i < REG_COUNT; i++) regs[i] = FACTORY_VALUES[i];
  endfunction

  function automatic void add_beat(logic kind, logic [7:0] reply, logic [3:0] idx,
                                   logic [7:0] val);
    beat_t b;
    b = '{kind, reply, idx, val, 1'b0};
    fresh_beats.push_back(b);
  endfunction

  // Advance the parser by one byte; the beats it causes land in fresh_beats.
  function automatic void parse_rx_byte(logic [7:0] b);
    logic [7:0] p, v, sum;
    beat_t      tail;
    case (phase)
      SEEK_FIRST:  if (b == HDR_BYTE) phase = SEEK_SECOND;
      SEEK_SECOND: phase = (b == HDR_BYTE) ? GET_ID : SEEK_FIRST;
      GET_ID: begin
        cur_id  = b;
        cur_sum = b;
        phase   = GET_INSTR;
      end
      GET_INSTR: begin
        cur_instr = b;
        cur_sum   = cur_sum + b;
        phase     = GET_LEN;
      end
      GET_LEN: begin
        cur_len   = b;
        cur_sum   = cur_sum + b;
        cur_count = 0;
        if (b > MAX_LEN) phase = SEEK_FIRST;
        else phase = (b == 0) ? GET_CHECK : GET_PAYLOAD;
      end
      GET_PAYLOAD: begin
        if (b == HDR_BYTE || cur_count >= MAX_LEN) begin
          phase = SEEK_FIRST;
        end else begin
          cur_payload[cur_count] = b;
          cur_sum = cur_sum + b;
          cur_count++;
          if (cur_count >= cur_len) phase = GET_CHECK;
        end
      end
      GET_CHECK: begin
        phase = SEEK_FIRST;
        if (8'hFF - cur_sum == b) begin
          if (cur_instr == INSTR_WRITE) begin
            for (int i = 0; i + 1 < cur_len && i + 1 < MAX_LEN; i += 2) begin
              p = cur_payload[i];
              v = cur_payload[i + 1];
              if (p < REG_COUNT) begin
                regs[p] = v;
                add_beat(1'b1, 8'h00, p[3:0], v);
              end
            end
          end else if (cur_instr == INSTR_READ) begin
            sum = cur_id + INSTR_READ + cur_len;
            add_beat(1'b0, HDR_BYTE, 4'd0, 8'h00);
            add_beat(1'b0, HDR_BYTE, 4'd0, 8'h00);
            add_beat(1'b0, cur_id, 4'd0, 8'h00);
            add_beat(1'b0, INSTR_READ, 4'd0, 8'h00);
            add_beat(1'b0, cur_len, 4'd0, 8'h00);
            for (int i = 0; i < cur_len && i < MAX_LEN; i++) begin
              p = cur_payload[i];
              v = (p < REG_COUNT) ? regs[p] : 8'h00;
              add_beat(1'b0, p, 4'd0, 8'h00);
              add_beat(1'b0, v, 4'd0, 8'h00);
              sum = sum + p + v;
            end
            add_beat(1'b0, 8'hFF - sum, 4'd0, 8'h00);
          end else if (cur_instr == INSTR_RESET) begin
            restore_regs();
          end
        end
      end
      default: phase = SEEK_FIRST;
    endcase
    if (fresh_beats.size() > 0) begin
      tail = fresh_beats.pop_back();
      tail.last = 1'b1;
      fresh_beats.push_back(tail);
    end
  endfunction

  // Present one byte after a random gap, wait for the handshake, then record
  // what it should cause: typed-in beats for scripted rows, else the model's.
  task automatic send_byte(input logic [7:0] b, input int ntyped);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    parse_rx_byte(b);
    if (ntyped > 0) begin
      repeat (ntyped) begin
        pending_beats.push_back(SCRIPT_BEATS[typed_pos]);
        typed_pos++;
      end
    end else begin
      while (fresh_beats.size() > 0) pending_beats.push_back(fresh_beats.pop_front());
    end
    fresh_beats.delete();
    bytes_sent++;
  endtask

  // Hold the stream until every outstanding beat has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_beats.size() != 0);
  endtask

  // Mostly well-formed packets with random content, the rest noise and broken ones.
  task automatic send_packet();
    logic [7:0] pkt [$];
    logic [7:0] id, instr, len, sum, b;
    int         sel, cut;
    sel = $urandom_range(0, 99);
    id  = 8'($urandom_range(0, 255));
    if (sel < 80) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: instr = INSTR_READ;
        4, 5, 6, 7: instr = INSTR_WRITE;
        8:          instr = INSTR_RESET;
        default:    instr = 8'($urandom_range(4, 255));
      endcase
      len = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, MAX_LEN))
                                        : 8'($urandom_range(0, 4));
      pkt.push_back(HDR_BYTE);
      pkt.push_back(HDR_BYTE);
      pkt.push_back(id);
      pkt.push_back(instr);
      pkt.push_back(len);
      sum = id + instr + len;
      for (int i = 0; i < len; i++) begin
        if (instr == INSTR_WRITE && i % 2 == 1) b = 8'($urandom_range(0, 254));
        else if ($urandom_range(0, 7) == 0)     b = 8'($urandom_range(0, 254));
        else                                    b = 8'($urandom_range(0, REG_COUNT - 1));
        sum = sum + b;
        pkt.push_back(b);
      end
      b = 8'hFF - sum;
      if ($urandom_range(0, 9) == 0) b = b ^ 8'($urandom_range(1, 255));
      pkt.push_back(b);
    end else begin
      case ($urandom_range(0, 3))
        0: repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom_range(0, 255)));
        1, 3: begin
          // packet cut short, or one with FF inside its payload
          len = 8'($urandom_range(1, MAX_LEN));
          cut = $urandom_range(0, len - 1);
          pkt.push_back(HDR_BYTE);
          pkt.push_back(HDR_BYTE);
          pkt.push_back(id);
          pkt.push_back($urandom_range(0, 1) ? INSTR_READ : INSTR_WRITE);
          pkt.push_back(len);
          repeat (cut) pkt.push_back(8'($urandom_range(0, 254)));
          if (sel % 2 == 0) pkt.push_back(HDR_BYTE);
        end
        default: begin
          pkt.push_back(HDR_BYTE);
          pkt.push_back(HDR_BYTE);
          pkt.push_back(id);
          pkt.push_back(8'($urandom_range(0, 255)));
          pkt.push_back(8'($urandom_range(MAX_LEN + 1, 255)));
        end
      endcase
    end
    foreach (pkt[i]) send_byte(pkt[i], 0);
    packets_sent++;
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // result side: random stall before each beat
  initial begin
    int stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin : result_check
    beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected: tdata 0x%0h tuser %b tlast %b",
               m_tdata, m_tuser, m_tlast);
        mismatches++;
      end else begin
        want = pending_beats.pop_front();
        check_field("kind", 8'(want.kind), 8'(m_tuser));
        check_field("reply_byte", want.reply, m_tdata[7:0]);
        check_field("param_index", 8'(want.idx), 8'(m_tdata[11:8]));
        check_field("param_value", want.val, m_tdata[19:12]);
        check_field("last", 8'(want.last), 8'(m_tlast));
        beats_checked++;
        if (want.kind) updates_seen++;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("servo_packet_parameter_store_core_tb: FAIL");
      $finish;
    end
  end

  initial begin
    phase     = SEEK_FIRST;
    cur_id    = '0;
    cur_instr = '0;
    cur_len   = '0;
    cur_sum   = '0;
    cur_count = 0;
    for (int i = 0; i < MAX_LEN; i++) cur_payload[i] = '0;
    restore_regs();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++) send_byte(SCRIPT[i].rx, SCRIPT[i].ntyped);
    drain();

    while (bytes_sent < SCRIPT_LEN + RANDOM_BYTES) begin
      steady = ((packets_sent / 8) % 4 == 2);
      send_packet();
      if (packets_sent % 12 == 0) drain();
    end
    steady = 1'b0;

    drain();
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d bytes (%0d scripted, %0d random packets); checked %0d result beats,",
             bytes_sent, SCRIPT_LEN, packets_sent, beats_checked);
    $display("  %0d register updates and %0d reply bytes.",
             updates_seen, beats_checked - updates_seen);
    if (mismatches == 0) begin
      $display("servo_packet_parameter_store_core_tb: PASS");
    end else begin
      $display("servo_packet_parameter_store_core_tb: FAIL");
    end
    $finish;
  end

endmodule

### servo_packet_parameter_store_core.f
hdl/spps_pkg.sv
hdl/spps_front.sv
hdl/spps_queue.sv
hdl/spps_back.sv
hdl/servo_packet_parameter_store_core.sv
tb/servo_packet_parameter_store_core_tb.sv
